// ===== sv/epa_pkg.sv =====
// shared types and constants for the encoder period averager
`default_nettype none
package epa_pkg;

  localparam int unsigned WINDOW_DEF = 32;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned PERIOD_W = 24;
  localparam int unsigned DEB_W    = 16;
  localparam int unsigned MAXP_W   = 24;
  localparam int unsigned TOUT_W   = 32;
  localparam int unsigned STATUS_W = 3;

  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MAX_PER  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_TIMEOUT  = 2'd2;

  localparam logic [DEB_W-1:0]  DEBOUNCE_RST = 16'd400;
  localparam logic [MAXP_W-1:0] MAX_PER_RST  = 24'd1000000;
  localparam logic [TOUT_W-1:0] TIMEOUT_RST  = 32'd1000000;

  typedef enum logic [STATUS_W-1:0] {
    ST_AVERAGED  = 3'd0,
    ST_DEBOUNCED = 3'd1,
    ST_PIN_LOW   = 3'd2,
    ST_TOO_LONG  = 3'd3,
    ST_QUERY     = 3'd4
  } status_e;

  typedef struct packed {
    logic [DEB_W-1:0]  debounce_us;
    logic [MAXP_W-1:0] max_period_us;
    logic [TOUT_W-1:0] stop_timeout_us;
  } cfg_t;

endpackage
`default_nettype wire

// ===== sv/epa_ram.sv =====
// generic single-port-write ram with registered read
`default_nettype none
module epa_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== sv/epa_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none
module epa_div #(
  parameter int unsigned DIVIDEND_W = 29,
  parameter int unsigned DIVISOR_W  = 6
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [DIVIDEND_W-1:0] dividend_i,
  input  wire logic [DIVISOR_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic      [DIVIDEND_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  div_q;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  done_q, done_d;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  always_comb begin
    trial = {rem_q, quo_q[DIVIDEND_W-1]};
    fits  = trial >= {1'b0, div_q};
    diff  = trial - {1'b0, div_q};
    rem_d = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    quo_d = {quo_q[DIVIDEND_W-2:0], fits};
    cnt_d = cnt_q - 1'b1;
    done_d = (cnt_q == CNT_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CNT_W'(DIVIDEND_W);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (cnt_q != '0) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

// ===== sv/epa_cfg.sv =====
// apb configuration registers
`default_nettype none
module epa_cfg (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [epa_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [epa_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [epa_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                   pready,
  output epa_pkg::cfg_t                          cfg_o
);
  import epa_pkg::*;

  cfg_t                 cfg_q;
  logic [REG_IDX_W-1:0] idx;
  logic                 wr;

  assign idx = paddr[APB_ADDR_W-1:2];
  assign wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_us     <= DEBOUNCE_RST;
      cfg_q.max_period_us   <= MAX_PER_RST;
      cfg_q.stop_timeout_us <= TIMEOUT_RST;
    end else if (wr) begin
      unique case (idx)
        REG_DEBOUNCE: cfg_q.debounce_us     <= pwdata[DEB_W-1:0];
        REG_MAX_PER:  cfg_q.max_period_us   <= pwdata[MAXP_W-1:0];
        REG_TIMEOUT:  cfg_q.stop_timeout_us <= pwdata[TOUT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DEBOUNCE: prdata = APB_DATA_W'(cfg_q.debounce_us);
      REG_MAX_PER:  prdata = APB_DATA_W'(cfg_q.max_period_us);
      REG_TIMEOUT:  prdata = APB_DATA_W'(cfg_q.stop_timeout_us);
      default:      prdata = '0;
    endcase
  end

  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

endmodule
`default_nettype wire

// ===== sv/encoder_period_averager_top.sv =====
// encoder period averager: pulse qualification, period window and average
// queries and edges that are not averaged go from idle to the output state and then to the
// result register; averaged edges pass through the subtract, add and divide states first
// the divide state waits on the bit-serial divider, one quotient bit per cycle
// one item at a time; a new item is taken while the previous result waits for transfer
// reset clears window count, sum, average and last pulse time; window entries are
// not subtracted until the window has filled, so no clearing pass is needed
`default_nettype none
module encoder_period_averager_top #(
  parameter int unsigned WINDOW = epa_pkg::WINDOW_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              cmd_i,
  input  wire logic [epa_pkg::TIME_W-1:0]        now_us_i,
  input  wire logic                              pin_high_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic      [epa_pkg::STATUS_W-1:0]      status_o,
  output logic      [epa_pkg::PERIOD_W-1:0]      avg_us_o,
  output logic                                   stopped_o,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [epa_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [epa_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [epa_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                   pready
);
  import epa_pkg::*;

  localparam int unsigned SLOT_W = $clog2(WINDOW);
  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W  = PERIOD_W + $clog2(WINDOW);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUB  = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  cfg_t cfg;

  logic [2:0]          state_q, state_d;
  logic [TIME_W-1:0]   last_q, last_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic                full_q, full_d;
  logic [PERIOD_W-1:0] avg_q, avg_d;
  logic                out_valid_q, out_valid_d;

  logic [PERIOD_W-1:0] dt_q, dt_d;
  status_e             res_status_q, res_status_d;
  logic [PERIOD_W-1:0] res_avg_q, res_avg_d;
  logic                res_stop_q, res_stop_d;
  status_e             out_status_q;
  logic [PERIOD_W-1:0] out_avg_q;
  logic                out_stop_q;

  logic [TIME_W-1:0]   dt_now;
  logic                accept;
  logic                load_out;
  logic [SUM_W-1:0]    sum_add;
  logic                slot_wrap;
  logic [SLOT_W-1:0]   slot_next;
  logic                full_next;
  logic [CNT_W-1:0]    divisor;
  logic                div_start;
  logic                div_done;
  logic [SUM_W-1:0]    quotient;
  logic                ram_we;
  logic [PERIOD_W-1:0] ram_rdata;

  epa_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  epa_ram #(
    .WIDTH (PERIOD_W),
    .DEPTH (WINDOW)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (dt_q),
    .raddr_i (slot_q),
    .rdata_o (ram_rdata)
  );

  epa_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_add),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign dt_now     = now_us_i - last_q;
  assign ram_we     = (state_q == S_SUB);
  assign div_start  = (state_q == S_ADD);
  assign load_out   = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  assign sum_add   = sum_q + SUM_W'(dt_q);
  assign slot_wrap = ({1'b0, slot_q} + 1'b1) == (SLOT_W + 1)'(WINDOW);
  assign slot_next = slot_wrap ? '0 : slot_q + 1'b1;
  assign full_next = full_q || slot_wrap;
  assign divisor   = full_next ? CNT_W'(WINDOW) : CNT_W'(slot_next);

  always_comb begin
    state_d      = state_q;
    last_d       = last_q;
    sum_d        = sum_q;
    slot_d       = slot_q;
    full_d       = full_q;
    avg_d        = avg_q;
    dt_d         = dt_q;
    res_status_d = res_status_q;
    res_avg_d    = res_avg_q;
    res_stop_d   = res_stop_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_avg_d  = avg_q;
          res_stop_d = 1'b0;
          state_d    = S_OUT;
          if (cmd_i) begin
            res_status_d = ST_QUERY;
            res_stop_d   = (dt_now > cfg.stop_timeout_us) || (avg_q == '0);
          end else if (dt_now < TIME_W'(cfg.debounce_us)) begin
            res_status_d = ST_DEBOUNCED;
          end else if (!pin_high_i) begin
            res_status_d = ST_PIN_LOW;
          end else begin
            last_d = now_us_i;
            if (dt_now >= TIME_W'(cfg.max_period_us)) begin
              res_status_d = ST_TOO_LONG;
            end else begin
              res_status_d = ST_AVERAGED;
              dt_d         = dt_now[PERIOD_W-1:0];
              state_d      = S_SUB;
            end
          end
        end
      end
      S_SUB: begin
        sum_d   = sum_q - (full_q ? SUM_W'(ram_rdata) : '0);
        state_d = S_ADD;
      end
      S_ADD: begin
        sum_d   = sum_add;
        slot_d  = slot_next;
        full_d  = full_next;
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          avg_d     = quotient[PERIOD_W-1:0];
          res_avg_d = quotient[PERIOD_W-1:0];
          state_d   = S_OUT;
        end
      end
      S_OUT: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      last_q      <= '0;
      sum_q       <= '0;
      slot_q      <= '0;
      full_q      <= 1'b0;
      avg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      sum_q       <= sum_d;
      slot_q      <= slot_d;
      full_q      <= full_d;
      avg_q       <= avg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dt_q         <= dt_d;
    res_status_q <= res_status_d;
    res_avg_q    <= res_avg_d;
    res_stop_q   <= res_stop_d;
    if (load_out) begin
      out_status_q <= res_status_q;
      out_avg_q    <= res_avg_q;
      out_stop_q   <= res_stop_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign avg_us_o    = out_avg_q;
  assign stopped_o   = out_stop_q;

endmodule
`default_nettype wire

// ===== sv/epa_checker.sv =====
// port-level checks for the encoder period averager, bound to the top level
`default_nettype none
module epa_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_valid_i,
  input wire logic                           in_ready_o,
  input wire logic                           out_valid_o,
  input wire logic                           out_ready_i,
  input wire logic [epa_pkg::STATUS_W-1:0]   status_o,
  input wire logic [epa_pkg::PERIOD_W-1:0]   avg_us_o,
  input wire logic                           stopped_o
);
  import epa_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(status_o) && $stable(avg_us_o) && $stable(stopped_o))
    else $error("result changed before transfer");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an item is in progress");

  a_edge_not_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_QUERY) |-> !stopped_o)
    else $error("stopped flag on an edge result");

  a_zero_avg_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_QUERY) && (avg_us_o == '0) |-> stopped_o)
    else $error("zero average not reported as stopped");

endmodule

bind encoder_period_averager_top epa_checker u_epa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o),
  .avg_us_o    (avg_us_o),
  .stopped_o   (stopped_o)
);
`default_nettype wire

// ===== verif/encoder_period_averager_checker.sv =====
// checker for the encoder period averager: watches all channels, predicts and compares results
`timescale 1ns / 1ps
module encoder_period_averager_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  input  wire logic                           in_ready_i,
  input  wire logic                           cmd_i,
  input  wire logic [epa_pkg::TIME_W-1:0]     now_us_i,
  input  wire logic                           pin_high_i,
  input  wire logic                           out_valid_i,
  input  wire logic                           out_ready_i,
  input  wire logic [epa_pkg::STATUS_W-1:0]   status_i,
  input  wire logic [epa_pkg::PERIOD_W-1:0]   avg_us_i,
  input  wire logic                           stopped_i,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [epa_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [epa_pkg::APB_DATA_W-1:0] pwdata,
  input  wire logic [epa_pkg::APB_DATA_W-1:0] prdata,
  input  wire logic                           pready,
  output int                                  fail_count_o,
  output int                                  pending_o,
  output int                                  n_averaged_o,
  output int                                  n_rejected_o,
  output int                                  n_queries_o,
  output int                                  n_stopped_o,
  output int                                  n_wraps_o
);
  import epa_pkg::*;

  localparam int unsigned WINDOW = WINDOW_DEF;
  localparam int unsigned SLOT_W = $clog2(WINDOW);
  localparam int unsigned SUM_W  = PERIOD_W + SLOT_W;

  typedef struct packed {
    status_e               status;
    logic [PERIOD_W-1:0]   avg_us;
    logic                  stopped;
  } period_result_t;

  cfg_t                  cfg_q;
  logic [PERIOD_W-1:0]   period_hist [WINDOW];
  logic [SLOT_W-1:0]     hist_slot;
  logic                  hist_full;
  logic [SUM_W-1:0]      hist_sum;
  logic [PERIOD_W-1:0]   avg_period;
  logic [TIME_W-1:0]     last_pulse_us;
  period_result_t        expected_results [$];

  function automatic period_result_t advance_period_average(logic cmd, logic [TIME_W-1:0] now,
                                                            logic pin);
    period_result_t res;
    logic [TIME_W-1:0] dt;
    logic [SUM_W-1:0]  quot;
    dt = now - last_pulse_us;
    res.status  = ST_QUERY;
    res.stopped = 1'b0;
    if (cmd) begin
      res.stopped = (dt > cfg_q.stop_timeout_us) || (avg_period == '0);
    end else if (dt < TIME_W'(cfg_q.debounce_us)) begin
      res.status = ST_DEBOUNCED;
    end else if (!pin) begin
      res.status = ST_PIN_LOW;
    end else begin
      last_pulse_us = now;
      if (dt >= TIME_W'(cfg_q.max_period_us)) begin
        res.status = ST_TOO_LONG;
      end else begin
        res.status = ST_AVERAGED;
        hist_sum = hist_sum - SUM_W'(period_hist[hist_slot]) + SUM_W'(dt[PERIOD_W-1:0]);
        period_hist[hist_slot] = dt[PERIOD_W-1:0];
        hist_slot = (hist_slot == SLOT_W'(WINDOW - 1)) ? '0 : hist_slot + 1'b1;
        if (hist_slot == '0) begin
          hist_full = 1'b1;
        end
        if (hist_full) begin
          quot = hist_sum / SUM_W'(WINDOW);
        end else begin
          quot = hist_sum / SUM_W'(hist_slot);
        end
        avg_period = quot[PERIOD_W-1:0];
      end
    end
    res.avg_us = avg_period;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    period_result_t want;
    logic [APB_DATA_W-1:0] reg_value;
    if (!rst_ni) begin
      cfg_q = '{debounce_us: DEBOUNCE_RST, max_period_us: MAX_PER_RST,
                stop_timeout_us: TIMEOUT_RST};
      for (int i = 0; i < WINDOW; i++) begin
        period_hist[i] = '0;
      end
      hist_slot     = '0;
      hist_full     = 1'b0;
      hist_sum      = '0;
      avg_period    = '0;
      last_pulse_us = '0;
      expected_results.delete();
      fail_count_o  = 0;
      n_averaged_o  = 0;
      n_rejected_o  = 0;
      n_queries_o   = 0;
      n_stopped_o   = 0;
      n_wraps_o     = 0;
    end else begin
      // result transfer
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result with no item waiting: status %0d avg_us %0d stopped %0d",
                 status_i, avg_us_i, stopped_i);
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          if (status_i !== want.status) begin
            $error("status mismatch: expected %0d actual %0d", want.status, status_i);
            fail_count_o++;
          end
          if (avg_us_i !== want.avg_us) begin
            $error("avg_us mismatch: expected %0d actual %0d", want.avg_us, avg_us_i);
            fail_count_o++;
          end
          if (stopped_i !== want.stopped) begin
            $error("stopped mismatch: expected %0d actual %0d", want.stopped, stopped_i);
            fail_count_o++;
          end
        end
      end
      // item transfer
      if (in_valid_i && in_ready_i) begin
        want = advance_period_average(cmd_i, now_us_i, pin_high_i);
        expected_results.push_back(want);
        case (want.status)
          ST_AVERAGED: begin
            n_averaged_o++;
            if (hist_slot == '0) begin
              n_wraps_o++;
            end
          end
          ST_QUERY: begin
            n_queries_o++;
            if (want.stopped) begin
              n_stopped_o++;
            end
          end
          default: n_rejected_o++;
        endcase
      end
      // register access
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[APB_ADDR_W-1:2])
            REG_DEBOUNCE: cfg_q.debounce_us     = pwdata[DEB_W-1:0];
            REG_MAX_PER:  cfg_q.max_period_us   = pwdata[MAXP_W-1:0];
            REG_TIMEOUT:  cfg_q.stop_timeout_us = pwdata[TOUT_W-1:0];
            default: ;
          endcase
        end else begin
          case (paddr[APB_ADDR_W-1:2])
            REG_DEBOUNCE: reg_value = APB_DATA_W'(cfg_q.debounce_us);
            REG_MAX_PER:  reg_value = APB_DATA_W'(cfg_q.max_period_us);
            REG_TIMEOUT:  reg_value = APB_DATA_W'(cfg_q.stop_timeout_us);
            default:      reg_value = '0;
          endcase
          if (prdata !== reg_value) begin
            $error("prdata mismatch at paddr %0d: expected %0d actual %0d",
                   paddr, reg_value, prdata);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = expected_results.size();
  end

endmodule

// ===== verif/testbench.sv =====
// testbench top for the encoder period averager: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module testbench;
  import epa_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT  = 5000;
  localparam int unsigned LONG_HOLD       = 400;
  localparam int unsigned DRAIN_CYCLES    = 40;
  localparam int unsigned RANDOM_PHASES   = 4;
  localparam int unsigned ITEMS_PER_PHASE = 200;

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic                  cmd_i       = 1'b0;
  logic [TIME_W-1:0]     now_us_i    = '0;
  logic                  pin_high_i  = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [STATUS_W-1:0]   status_o;
  logic [PERIOD_W-1:0]   avg_us_o;
  logic                  stopped_o;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [APB_ADDR_W-1:0] paddr       = '0;
  logic [APB_DATA_W-1:0] pwdata      = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int fail_count;
  int pending;
  int n_averaged;
  int n_rejected;
  int n_queries;
  int n_stopped;
  int n_wraps;

  // presumed time of the last accepted pulse, used to shape the items
  logic [TIME_W-1:0] cursor_us = '0;
  logic [DEB_W-1:0]  deb_cfg   = DEBOUNCE_RST;
  logic [MAXP_W-1:0] maxp_cfg  = MAX_PER_RST;
  logic [TOUT_W-1:0] tout_cfg  = TIMEOUT_RST;
  bit                no_gaps     = 1'b0;
  int                hold_token  = 0;
  int                n_sent      = 0;
  int                n_settings  = 1;
  int                idle_cycles = 0;

  encoder_period_averager_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .now_us_i    (now_us_i),
    .pin_high_i  (pin_high_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .avg_us_o    (avg_us_o),
    .stopped_o   (stopped_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  encoder_period_averager_checker period_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .cmd_i        (cmd_i),
    .now_us_i     (now_us_i),
    .pin_high_i   (pin_high_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_i     (status_o),
    .avg_us_i     (avg_us_o),
    .stopped_i    (stopped_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .n_averaged_o (n_averaged),
    .n_rejected_o (n_rejected),
    .n_queries_o  (n_queries),
    .n_stopped_o  (n_stopped),
    .n_wraps_o    (n_wraps)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    if (no_gaps) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 88) begin
      return $urandom_range(1, 3);
    end
    if (r < 98) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // period between debounce and max period, mostly short, sometimes at the limits
  function automatic logic [TIME_W-1:0] pick_period();
    logic [TIME_W-1:0] room;
    int r;
    if (TIME_W'(maxp_cfg) <= TIME_W'(deb_cfg)) begin
      return TIME_W'(deb_cfg);
    end
    room = TIME_W'(maxp_cfg) - TIME_W'(deb_cfg) - 1;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      return TIME_W'(deb_cfg) + room;
    end
    if (r < 10) begin
      return TIME_W'(deb_cfg);
    end
    if (r < 75) begin
      return TIME_W'(deb_cfg) + $urandom_range(0, (room < 3000) ? room : 3000);
    end
    return TIME_W'(deb_cfg) + $urandom_range(0, room);
  endfunction

  task automatic push_item(logic cmd, logic [TIME_W-1:0] now, logic pin);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    now_us_i   <= now;
    pin_high_i <= pin;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    n_sent++;
  endtask

  task automatic send_edge(logic [TIME_W-1:0] dt, logic pin);
    cursor_us = cursor_us + dt;
    push_item(1'b0, cursor_us, pin);
  endtask

  task automatic send_query(logic [TIME_W-1:0] dt);
    cursor_us = cursor_us + dt;
    push_item(1'b1, cursor_us, $urandom_range(0, 1) != 0);
  endtask

  task automatic apb_xfer(logic wr, logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= APB_ADDR_W'({idx, 2'b00});
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  // unused upper data bits carry noise, then every register is read back
  task automatic set_config(logic [DEB_W-1:0] deb, logic [MAXP_W-1:0] maxp,
                            logic [TOUT_W-1:0] tout);
    logic [APB_DATA_W-1:0] junk;
    junk     = $urandom();
    deb_cfg  = deb;
    maxp_cfg = maxp;
    tout_cfg = tout;
    apb_xfer(1'b1, REG_DEBOUNCE, {junk[31:16], deb});
    apb_xfer(1'b1, REG_MAX_PER, {junk[7:0], maxp});
    apb_xfer(1'b1, REG_TIMEOUT, tout);
    apb_xfer(1'b0, REG_DEBOUNCE, '0);
    apb_xfer(1'b0, REG_MAX_PER, '0);
    apb_xfer(1'b0, REG_TIMEOUT, '0);
    n_settings++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic random_item();
    int r;
    logic [TIME_W-1:0] dt;
    logic [TIME_W-1:0] now;
    logic pin;
    r = $urandom_range(0, 99);
    if (r < 62) begin
      dt  = pick_period();
      pin = ($urandom_range(0, 19) != 0);
      now = cursor_us + dt;
      if (pin) begin
        cursor_us = now;
      end
      push_item(1'b0, now, pin);
    end else if (r < 78) begin
      case ($urandom_range(0, 2))
        0:       dt = TIME_W'(tout_cfg) + $urandom_range(0, 2) - 1;
        1:       dt = $urandom_range(0, 1000);
        default: dt = $urandom();
      endcase
      push_item(1'b1, cursor_us + dt, $urandom_range(0, 1) != 0);
    end else if (r < 84) begin
      dt = (deb_cfg == '0) ? '0 : $urandom_range(0, deb_cfg - 1);
      push_item(1'b0, cursor_us + dt, $urandom_range(0, 1) != 0);
    end else if (r < 89) begin
      push_item(1'b0, cursor_us + pick_period(), 1'b0);
    end else if (r < 94) begin
      dt  = TIME_W'(maxp_cfg) + $urandom_range(0, 5000);
      now = cursor_us + dt;
      if (dt >= TIME_W'(deb_cfg)) begin
        cursor_us = now;
      end
      push_item(1'b0, now, 1'b1);
    end else begin
      now = $urandom();
      pin = ($urandom_range(0, 1) != 0);
      if (pin && ((now - cursor_us) >= TIME_W'(deb_cfg))) begin
        cursor_us = now;
      end
      push_item(1'b0, now, pin);
    end
  endtask

  // receiver: random ready, one long hold-off per request from the stimulus
  initial begin : result_sink
    int hold_seen;
    int span;
    int r;
    logic lvl;
    hold_seen = 0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        lvl  = 1'b0;
        span = LONG_HOLD;
      end else if (no_gaps) begin
        lvl  = 1'b1;
        span = 1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          lvl  = 1'b1;
          span = $urandom_range(1, 4);
        end else if (r < 92) begin
          lvl  = 1'b0;
          span = $urandom_range(1, 3);
        end else if (r < 98) begin
          lvl  = 1'b0;
          span = $urandom_range(5, 20);
        end else begin
          lvl  = 1'b0;
          span = $urandom_range(30, 80);
        end
      end
      out_ready_i <= lvl;
      repeat (span - 1) @(negedge clk_i);
    end
  end

  initial begin : watchdog
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("encoder_period_averager_top test failed");
    $finish;
  end

  initial begin : stimulus
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: zero average, debounce and pin checks, limits, timeout, wrap
    send_query(0);
    send_edge(100, 1'b1);
    send_edge(400, 1'b0);
    send_edge(0, 1'b1);
    send_edge(399, 1'b1);
    send_edge(1, 1'b1);
    send_edge(999999, 1'b1);
    send_edge(1000000, 1'b1);
    send_query(1000000);
    send_query(1);
    cursor_us = 32'hFFFF_FE00;
    send_edge(0, 1'b1);
    send_edge(32'h0000_0300, 1'b1);
    cursor_us = 32'hFFFF_FFFF;
    send_query(0);

    wait_idle();
    set_config('0, 24'hFF_FFFF, 32'hFFFF_FFFF);
    cursor_us = 32'h0000_0100;
    send_edge(0, 1'b1);
    send_edge(32'h00FF_FFFE, 1'b1);
    send_query(0);
    send_edge(32'h00FF_FFFF, 1'b1);

    // zero max period: every accepted edge is too long
    wait_idle();
    set_config(16'hFFFF, '0, '0);
    send_edge(65534, 1'b1);
    send_edge(1, 1'b1);
    send_query(1);

    wait_idle();
    set_config('0, 24'd1, '0);
    send_edge(0, 1'b1);
    send_edge(0, 1'b1);
    send_query(0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      case (p)
        0: set_config(DEB_W'($urandom_range(0, 500)), MAXP_W'($urandom_range(2000, 50000)),
                      TOUT_W'($urandom_range(1000, 100000)));
        1: set_config(16'hFFFF, 24'hFF_FFFF, 32'hFFFF_FFFF);
        2: set_config('0, MAXP_W'($urandom_range(1, 300)), '0);
        default: set_config(DEB_W'($urandom_range(0, 65535)),
                            MAXP_W'($urandom_range(1, 24'hFF_FFFF)), TOUT_W'($urandom()));
      endcase
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i == 20 && (p % 2) == 0) begin
          hold_token++;
        end
        no_gaps = (i >= 100 && i < 140);
        random_item();
      end
      no_gaps = 1'b0;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("run covered %0d items over %0d register settings: %0d averaged, %0d rejected",
             n_sent, n_settings, n_averaged, n_rejected);
    $display("%0d queries (%0d stopped), period window wrapped %0d times", n_queries,
             n_stopped, n_wraps);
    if (fail_count == 0) begin
      $display("encoder_period_averager_top test passed");
    end else begin
      $display("encoder_period_averager_top test failed");
    end
    $finish;
  end

endmodule
